[rtl/core/wsfd_pkg.sv]
package wsfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int TYPE_W       = 4;
   localparam int COUNT_W      = 4;
   localparam int DECODE_BYTES = 7;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hff;
   localparam logic [BYTE_W-1:0] SUM_SEED  = 8'hfe;

   localparam logic [TYPE_W-1:0] TYPE_WIND    = 4'd0;
   localparam logic [TYPE_W-1:0] TYPE_RAIN    = 4'd1;
   localparam logic [TYPE_W-1:0] TYPE_CHANNEL = 4'd2;
   localparam logic [TYPE_W-1:0] TYPE_OUTSIDE = 4'd3;
   localparam logic [TYPE_W-1:0] TYPE_POOL    = 4'd4;
   localparam logic [TYPE_W-1:0] TYPE_INDOOR  = 4'd5;
   localparam logic [TYPE_W-1:0] TYPE_FORECAST = 4'd6;

   localparam logic [3:0] SEEN_WIND    = 4'b0001;
   localparam logic [3:0] SEEN_RAIN    = 4'b0010;
   localparam logic [3:0] SEEN_OUTSIDE = 4'b0100;
   localparam logic [3:0] SEEN_INDOOR  = 4'b1000;

   localparam logic [10:0] PRESSURE_BYTE_BASE = 11'd795;
   localparam logic [10:0] PRESSURE_WIDE_BASE = 11'd600;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_SUM     = 2'd1,
      STATUS_BAD_CHANNEL = 2'd2
   } status_type;

   typedef logic [BYTE_W-1:0] frame_bytes_type [DECODE_BYTES];

   typedef struct packed {
      logic              done;
      logic              sum_bad;
      logic [TYPE_W-1:0] group_type;
   } event_type;

   typedef struct packed {
      status_type        status;
      logic [3:0]        group_type;
      logic [3:0]        battery;
      logic              is_primary;
      logic [1:0]        extra_slot;
      logic signed [11:0] value_a;
      logic [14:0]       value_b;
      logic [10:0]       value_c;
      logic [3:0]        tendency;
      logic [3:0]        sensors_seen;
   } result_type;

   function automatic logic [COUNT_W-1:0] payload_len(input logic [TYPE_W-1:0] t);
      logic [COUNT_W-1:0] len;
      case (t)
         4'd0:    len = 4'd8;
         4'd1:    len = 4'd13;
         4'd2:    len = 4'd6;
         4'd3:    len = 4'd6;
         4'd4:    len = 4'd4;
         4'd5:    len = 4'd10;
         4'd6:    len = 4'd11;
         4'd14:   len = 4'd2;
         4'd15:   len = 4'd6;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] bcd(input logic [7:0] x);
      return 8'(x[7:4]) * 8'd10 + 8'(x[3:0]);
   endfunction

endpackage

[rtl/core/wsfd_tracker.sv]
module wsfd_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [wsfd_pkg::BYTE_W-1:0]   rx_byte,
   output wsfd_pkg::event_type           frame_event,
   output wsfd_pkg::frame_bytes_type     frame_bytes
);
   import wsfd_pkg::*;

   logic [BYTE_W-1:0]  win0_ff, win0_in;
   logic [BYTE_W-1:0]  win1_ff, win1_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  bytes_ff [DECODE_BYTES];

   logic               sync_hit;
   logic               last_byte;
   logic               store_byte;
   logic [COUNT_W:0]   count_next;

   assign sync_hit = !in_frame_ff && (win0_ff == SYNC_BYTE) && (win1_ff == SYNC_BYTE)
                     && (rx_byte[7:4] == 4'd0);
   assign count_next = {1'b0, count_ff} + 5'd1;
   assign last_byte = in_frame_ff && (count_next >= {1'b0, payload_len(type_ff)});
   assign store_byte = step && in_frame_ff && !last_byte
                       && ({1'b0, count_ff} < 5'(DECODE_BYTES));

   always_comb begin
      frame_event.done       = last_byte
                               || (sync_hit && (payload_len(rx_byte[3:0]) == '0));
      frame_event.sum_bad    = sync_hit || (rx_byte != sum_ff);
      frame_event.group_type = sync_hit ? rx_byte[3:0] : type_ff;
   end

   always_comb begin
      win0_in     = win0_ff;
      win1_in     = win1_ff;
      count_in    = count_ff;
      in_frame_in = in_frame_ff;
      sum_in      = sum_ff;
      type_in     = type_ff;
      if (step) begin
         if (!in_frame_ff) begin
            if (sync_hit) begin
               win0_in     = '0;
               win1_in     = '0;
               type_in     = rx_byte[3:0];
               sum_in      = SUM_SEED + rx_byte;
               count_in    = '0;
               in_frame_in = (payload_len(rx_byte[3:0]) != '0);
            end else begin
               win0_in = win1_ff;
               win1_in = rx_byte;
            end
         end else if (!last_byte) begin
            sum_in   = sum_ff + rx_byte;
            count_in = count_next[COUNT_W-1:0];
         end else begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff     <= '0;
         win1_ff     <= '0;
         count_ff    <= '0;
         in_frame_ff <= 1'b0;
         sum_ff      <= '0;
         type_ff     <= '0;
      end else begin
         win0_ff     <= win0_in;
         win1_ff     <= win1_in;
         count_ff    <= count_in;
         in_frame_ff <= in_frame_in;
         sum_ff      <= sum_in;
         type_ff     <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         bytes_ff[count_ff[2:0]] <= rx_byte;
      end
   end

   assign frame_bytes = bytes_ff;

endmodule

[rtl/core/wsfd_decoder.sv]
module wsfd_decoder (
   input  wsfd_pkg::event_type       frame_event,
   input  wsfd_pkg::frame_bytes_type frame_bytes,
   input  logic [1:0]                outside_channel,
   input  logic [3:0]                seen,
   output wsfd_pkg::result_type      result,
   output logic [3:0]                seen_next
);
   import wsfd_pkg::*;

   logic [7:0]  p0, p1, p2, p3, p4, p5, p6;
   logic [11:0] low_reading;
   logic [11:0] temp_mag;
   logic [11:0] temp;
   logic [7:0]  humidity;
   logic [3:0]  hi0;
   logic [3:0]  ch2;
   logic [1:0]  ch2_slot;
   logic [2:0]  ch4;
   logic [1:0]  ch4_slot;

   assign p0 = frame_bytes[0];
   assign p1 = frame_bytes[1];
   assign p2 = frame_bytes[2];
   assign p3 = frame_bytes[3];
   assign p4 = frame_bytes[4];
   assign p5 = frame_bytes[5];
   assign p6 = frame_bytes[6];

   assign hi0         = p0[7:4];
   assign low_reading = 12'(bcd(p1)) + 12'(p2[3:0]) * 12'd100;
   assign temp_mag    = low_reading;
   assign temp        = p2[7] ? 12'(-temp_mag) : temp_mag;
   assign humidity    = bcd(p3);
   assign ch2         = p0[3:0];
   assign ch2_slot    = (ch2 == 4'd4) ? 2'd3 : ch2[1:0];

   always_comb begin
      case (p0[2:0])
         3'd2:    ch4 = 3'd2;
         3'd3:    ch4 = 3'd3;
         3'd4:    ch4 = 3'd3;
         default: ch4 = 3'd1;
      endcase
   end
   assign ch4_slot = 2'(ch4 - 3'd1);

   always_comb begin
      result              = '0;
      result.group_type   = frame_event.group_type;
      seen_next           = seen;
      if (frame_event.sum_bad) begin
         result.status = STATUS_BAD_SUM;
      end else begin
         result.status     = STATUS_OK;
         result.battery    = hi0;
         result.is_primary = 1'b1;
         case (frame_event.group_type)
            TYPE_WIND: begin
               seen_next      = seen | SEEN_WIND;
               result.value_a = low_reading;
               result.value_b = 15'(p2[7:4]) + 15'(humidity) * 15'd10;
               result.value_c = 11'(bcd(p4)) + 11'(p5[3:0]) * 11'd100;
            end
            TYPE_RAIN: begin
               seen_next      = seen | SEEN_RAIN;
               result.value_a = low_reading;
               result.value_b = 15'(humidity) + 15'(bcd(p4)) * 15'd100;
            end
            TYPE_CHANNEL: begin
               if (ch2 != 4'd1 && ch2 != 4'd2 && ch2 != 4'd4) begin
                  result         = '0;
                  result.status  = STATUS_BAD_CHANNEL;
                  result.group_type = TYPE_CHANNEL;
               end else begin
                  result.value_a = temp;
                  result.value_b = 15'(humidity);
                  if (outside_channel == ch2_slot) begin
                     seen_next      = seen | SEEN_OUTSIDE;
                     result.battery = {1'b0, hi0[2:0]};
                  end else begin
                     result.is_primary = 1'b0;
                     result.extra_slot = (outside_channel < ch2_slot) ?
                                         2'(ch2_slot - 2'd1) : ch2_slot;
                  end
               end
            end
            TYPE_OUTSIDE: begin
               result.value_a = temp;
               result.value_b = 15'(humidity);
               if (outside_channel == 2'd0) begin
                  seen_next      = seen | SEEN_OUTSIDE;
                  result.battery = {1'b0, hi0[2:0]};
               end else begin
                  result.is_primary = 1'b0;
               end
            end
            TYPE_POOL: begin
               result.value_a = temp;
               if (ch4 == 3'd1) begin
                  result.battery = {1'b0, hi0[2:0]};
               end else begin
                  result.is_primary = 1'b0;
                  result.extra_slot = ch4_slot;
               end
            end
            TYPE_INDOOR: begin
               seen_next      = seen | SEEN_INDOOR;
               result.value_a = temp;
               result.value_b = 15'(humidity);
               result.value_c = 11'(p5) + PRESSURE_BYTE_BASE;
            end
            TYPE_FORECAST: begin
               seen_next       = seen | SEEN_INDOOR;
               result.value_a  = temp;
               result.value_b  = 15'(humidity);
               result.value_c  = 11'({p6[0], p5}) + PRESSURE_WIDE_BASE;
               result.tendency = p6[7:4];
            end
            default: begin
               result.battery = '0;
            end
         endcase
      end
      result.sensors_seen = (result.status == STATUS_OK) ? seen_next : seen;
   end

endmodule

[rtl/core/weather_station_frame_decoder_top.sv]
// Weather station frame decoder.
//
// The req channel carries one received serial byte per word. The block hunts
// for the sync pattern ff ff followed by a type byte of 15 or less, collects
// that type's payload and checks the trailing checksum byte. When a frame
// ends, one word appears on the rsp channel with the status, the frame type,
// the decoded readings and the mask of sensor kinds seen since reset.
//
// A byte can be taken in every cycle unless a frame-ending byte waits on a
// stalled rsp channel. An accepted byte is held in the input register and is
// then folded into the frame state; the result of a frame's last byte goes to
// the result register. Throughput is one byte per cycle with that exception,
// set by the combinational frame update between input and result registers.
//
// When rsp is stalled the result register holds its word; further bytes that
// end no frame are still absorbed, and only a byte that would end a frame
// waits in the input register, which then drops req_ready.
//
// Reset empties both registers, clears the sync window, the frame state, the
// seen mask and the outside channel setting.
module weather_station_frame_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_group_type,
   output logic [3:0]         rsp_battery,
   output logic               rsp_is_primary,
   output logic [1:0]         rsp_extra_slot,
   output logic signed [11:0] rsp_value_a,
   output logic [14:0]        rsp_value_b,
   output logic [10:0]        rsp_value_c,
   output logic [3:0]         rsp_tendency,
   output logic [3:0]         rsp_sensors_seen,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_write_data
);
   import wsfd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_ff;
   logic [1:0]      outside_ff;
   logic [3:0]      seen_ff;

   logic            step;
   event_type       frame_event;
   frame_bytes_type frame_bytes;
   result_type      result;
   logic [3:0]      seen_next;

   assign step      = in_valid_ff && !(frame_event.done && rsp_valid_ff && !rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && frame_event.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   wsfd_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .frame_event (frame_event),
      .frame_bytes (frame_bytes)
   );

   wsfd_decoder u_decoder (
      .frame_event     (frame_event),
      .frame_bytes     (frame_bytes),
      .outside_channel (outside_ff),
      .seen            (seen_ff),
      .result          (result),
      .seen_next       (seen_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         outside_ff   <= '0;
         seen_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            outside_ff <= csr_write_data;
         end
         if (step && frame_event.done && !frame_event.sum_bad) begin
            seen_ff <= seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && frame_event.done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_group_type   = rsp_ff.group_type;
   assign rsp_battery      = rsp_ff.battery;
   assign rsp_is_primary   = rsp_ff.is_primary;
   assign rsp_extra_slot   = rsp_ff.extra_slot;
   assign rsp_value_a      = rsp_ff.value_a;
   assign rsp_value_b      = rsp_ff.value_b;
   assign rsp_value_c      = rsp_ff.value_c;
   assign rsp_tendency     = rsp_ff.tendency;
   assign rsp_sensors_seen = rsp_ff.sensors_seen;

endmodule

[rtl/core/wsfd_checker.sv]
module wsfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [3:0]         rsp_group_type,
   input logic [3:0]         rsp_battery,
   input logic               rsp_is_primary,
   input logic [1:0]         rsp_extra_slot,
   input logic signed [11:0] rsp_value_a,
   input logic [14:0]        rsp_value_b,
   input logic [10:0]        rsp_value_c,
   input logic [3:0]         rsp_tendency,
   input logic [3:0]         rsp_sensors_seen
);
   import wsfd_pkg::*;

   // A stalled result word must hold its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_group_type) && $stable(rsp_value_a) && $stable(rsp_sensors_seen))
      else $error("stalled rsp word changed");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // Failed frames carry no readings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_battery == '0 && rsp_value_a == '0
         && rsp_value_b == '0 && rsp_value_c == '0 && rsp_tendency == '0
         && !rsp_is_primary && rsp_extra_slot == '0)
      else $error("failed frame with readings");

   // A bad channel is only reported for channel sensor frames.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_CHANNEL |-> rsp_group_type == TYPE_CHANNEL)
      else $error("bad channel status on wrong frame type");

endmodule

bind weather_station_frame_decoder_top wsfd_checker u_wsfd_checker (.*);
